// ===== rtl/mkpd_pkg.sv =====
// Package for the matrix keypad scanner: shared widths, register defaults,
// register index codes and the state and result structs.
// No dependencies.
package mkpd_pkg;

   localparam int ROWS_DEFAULT = 4;
   localparam int COLS_DEFAULT = 4;

   localparam int TIME_W   = 32;
   localparam int MATRIX_W = 16;
   localparam int CODE_W   = 8;
   localparam int MAP_W    = 64;
   localparam int ROW_W    = 2;
   localparam int COL_W    = 2;
   localparam int IDX_W    = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 64;

   localparam logic [TIME_W-1:0] DEBOUNCE_RESET = 32'd50;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE_TIME = 2'd0,
      CSR_KEYMAP_LOW    = 2'd1,
      CSR_KEYMAP_HIGH   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [ROW_W-1:0]  scan_row;
      logic              waiting_release;
      logic [CODE_W-1:0] last_key;
      logic [TIME_W-1:0] last_key_time;
   } scan_state_type;

   typedef struct packed {
      logic              key_event;
      logic [CODE_W-1:0] key_code;
   } scan_result_type;

endpackage

// ===== rtl/matrix_keypad_scan_debounce.sv =====
// Top level of the matrix keypad scanner with debounce and release wait.
// Input register, decision logic (mkpd_scan_core), result register.
// Depends on mkpd_pkg and mkpd_scan_core.
//
//  Channel | Ports       | Direction | Contents
//  --------+-------------+-----------+------------------------------------------
//  req     | req_t*      | in        | one tick: timestamp and key snapshot
//  rsp     | rsp_t*      | out       | one result per tick: event flag and code
//  csr     | csr_*       | in        | register writes, no read-back
//
// One tick is accepted per cycle while the result register is empty or being taken;
// its result passes through the input register, then the result register, before it
// can transfer. Throughput is limited only by the downstream side: the input register
// advances whenever the result register is empty or being taken. Synchronous reset
// clears the pipeline and scan state, restores the default debounce time and clears
// the keymap. A stalled result holds while one more tick waits in the input register.
module matrix_keypad_scan_debounce #(
   parameter int ROWS = mkpd_pkg::ROWS_DEFAULT,
   parameter int COLS = mkpd_pkg::COLS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [47:0]                         req_tdata,  // [31:0] now_ms, [47:32] pressed_matrix
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,  // [7:0] key_code
   output logic                                rsp_tuser,  // [0] key_event
   input  logic                                csr_we,
   input  logic [mkpd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mkpd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic                             in_valid_ff, in_valid_in;
   logic [mkpd_pkg::TIME_W-1:0]      in_now_ff;
   logic [mkpd_pkg::MATRIX_W-1:0]    in_matrix_ff;
   logic                             rsp_valid_ff, rsp_valid_in;
   mkpd_pkg::scan_result_type        rsp_ff;
   mkpd_pkg::scan_state_type         state_ff, state_in;
   mkpd_pkg::scan_state_type         state_calc;
   mkpd_pkg::scan_result_type        result_calc;
   logic [mkpd_pkg::TIME_W-1:0]      debounce_ff;
   logic [mkpd_pkg::MAP_W-1:0]       keymap_low_ff;
   logic [mkpd_pkg::MAP_W-1:0]       keymap_high_ff;
   logic                             advance;
   logic                             req_xfer;
   logic                             process;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;
   assign process    = in_valid_ff && advance;

   mkpd_scan_core #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_core (
      .state_cur      (state_ff),
      .now_ms         (in_now_ff),
      .pressed_matrix (in_matrix_ff),
      .debounce_time  (debounce_ff),
      .keymap         ({keymap_high_ff, keymap_low_ff}),
      .state_nxt      (state_calc),
      .result         (result_calc)
   );

   assign in_valid_in  = req_xfer || (in_valid_ff && !advance);
   assign rsp_valid_in = process || (rsp_valid_ff && !rsp_tready);
   assign state_in     = process ? state_calc : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_now_ff    <= req_tdata[31:0];
         in_matrix_ff <= req_tdata[47:32];
      end
      if (process) begin
         rsp_ff <= result_calc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff    <= mkpd_pkg::DEBOUNCE_RESET;
         keymap_low_ff  <= '0;
         keymap_high_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            mkpd_pkg::CSR_DEBOUNCE_TIME: begin
               debounce_ff <= csr_wdata[mkpd_pkg::TIME_W-1:0];
            end
            mkpd_pkg::CSR_KEYMAP_LOW: begin
               keymap_low_ff <= csr_wdata;
            end
            mkpd_pkg::CSR_KEYMAP_HIGH: begin
               keymap_high_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.key_code;
   assign rsp_tuser  = rsp_ff.key_event;

   // a reported key always leaves the scanner waiting for release
   a_event_sets_wait: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.key_event) |-> state_ff.waiting_release)
      else $error("key event without release wait");

   a_code_zero_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.key_event) |-> (rsp_ff.key_code == '0))
      else $error("non-zero key code without event");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      int'(state_ff.scan_row) < ROWS)
      else $error("scan row out of range");

   // the row holds on a report and while waiting for release
   a_row_hold: assert property (@(posedge clock) disable iff (reset)
      (process && (result_calc.key_event || state_ff.waiting_release)) |=>
      $stable(state_ff.scan_row))
      else $error("scan row moved on report or release wait");

endmodule

// ===== rtl/mkpd_scan_core.sv =====
// Single-tick decision logic: release wait, row scan, key mapping and
// debounce check. Purely combinational.
// Depends on mkpd_pkg.
module mkpd_scan_core #(
   parameter int ROWS = mkpd_pkg::ROWS_DEFAULT,
   parameter int COLS = mkpd_pkg::COLS_DEFAULT
) (
   input  mkpd_pkg::scan_state_type          state_cur,
   input  logic [mkpd_pkg::TIME_W-1:0]       now_ms,
   input  logic [mkpd_pkg::MATRIX_W-1:0]     pressed_matrix,
   input  logic [mkpd_pkg::TIME_W-1:0]       debounce_time,
   input  logic [2*mkpd_pkg::MAP_W-1:0]      keymap,
   output mkpd_pkg::scan_state_type          state_nxt,
   output mkpd_pkg::scan_result_type         result
);

   localparam int KEYS = ROWS * COLS;
   localparam logic [mkpd_pkg::MATRIX_W-1:0] KEY_MASK =
      mkpd_pkg::MATRIX_W'((33'd1 << KEYS) - 33'd1);

   logic [mkpd_pkg::MATRIX_W-1:0] matrix_act;
   logic [COLS-1:0]               row_bits;
   logic                          row_ok;
   logic [mkpd_pkg::COL_W-1:0]    col_sel;
   logic [mkpd_pkg::IDX_W-1:0]    key_idx;
   logic [mkpd_pkg::CODE_W-1:0]   code;
   logic [mkpd_pkg::TIME_W-1:0]   elapsed;
   logic                          fire;
   logic [mkpd_pkg::ROW_W-1:0]    row_inc;

   assign matrix_act = pressed_matrix & KEY_MASK;
   assign row_ok     = int'(state_cur.scan_row) < ROWS;
   assign row_bits   = COLS'(matrix_act >> (int'(state_cur.scan_row) * COLS));

   // lowest pressed column wins
   always_comb begin
      col_sel = '0;
      for (int i = COLS - 1; i >= 0; i--) begin
         if (row_bits[i]) begin
            col_sel = mkpd_pkg::COL_W'(i);
         end
      end
   end

   assign key_idx = mkpd_pkg::IDX_W'(int'(state_cur.scan_row) * COLS + int'(col_sel));
   assign code    = keymap[key_idx*mkpd_pkg::CODE_W +: mkpd_pkg::CODE_W];
   assign elapsed = now_ms - state_cur.last_key_time;
   assign fire    = row_ok && (row_bits != '0) &&
                    ((elapsed >= debounce_time) || (code != state_cur.last_key));
   assign row_inc = state_cur.scan_row + mkpd_pkg::ROW_W'(1);

   always_comb begin
      state_nxt = state_cur;
      result    = '0;
      if (state_cur.waiting_release) begin
         if (matrix_act == '0) begin
            state_nxt.waiting_release = 1'b0;
         end
      end else if (fire) begin
         state_nxt.last_key        = code;
         state_nxt.last_key_time   = now_ms;
         state_nxt.waiting_release = 1'b1;
         result.key_event          = 1'b1;
         result.key_code           = code;
      end else begin
         state_nxt.scan_row = (int'(row_inc) >= ROWS) ? '0 : row_inc;
      end
   end

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for matrix_keypad_scan_debounce: directed ticks, then random
// key press/release sequences under several flow-control phases.
// Depends on mkpd_pkg and the RTL of the scanner.
`timescale 1ns / 100ps

module tb;

   localparam int ROWS          = mkpd_pkg::ROWS_DEFAULT;
   localparam int COLS          = mkpd_pkg::COLS_DEFAULT;
   localparam int SETTLE_CYCLES = 4;        // two-stage pipeline plus margin
   localparam int CYCLE_LIMIT   = 200_000;
   localparam int PHASE_ITEMS   = 375;
   localparam logic [mkpd_pkg::CSR_IDX_W-1:0] CSR_INDEX_UNUSED = 2'd3;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [47:0]                     req_tdata = '0;   // [31:0] now_ms, [47:32] pressed_matrix
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [7:0]                      rsp_tdata;        // [7:0] key_code
   logic                            rsp_tuser;        // [0] key_event
   logic                            csr_we = 1'b0;
   logic [mkpd_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [mkpd_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow copy of the scanner state and registers
   logic [mkpd_pkg::ROW_W-1:0]  m_row        = '0;
   logic                        m_waiting    = 1'b0;
   logic [mkpd_pkg::CODE_W-1:0] m_last_code  = '0;
   logic [mkpd_pkg::TIME_W-1:0] m_last_ms    = '0;
   logic [mkpd_pkg::TIME_W-1:0] m_debounce   = mkpd_pkg::DEBOUNCE_RESET;
   logic [mkpd_pkg::MAP_W-1:0]  m_map_lo     = '0;
   logic [mkpd_pkg::MAP_W-1:0]  m_map_hi     = '0;

   mkpd_pkg::scan_result_type pending_results[$];
   mkpd_pkg::scan_result_type oldest_result;
   logic [mkpd_pkg::TIME_W-1:0] tick_ms = '0;
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int errors        = 0;
   int cycle_count   = 0;

   matrix_keypad_scan_debounce #(.ROWS(ROWS), .COLS(COLS)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // one tick of the scanner: release wait, row scan, debounce decision
   task automatic predict_scan(input logic [mkpd_pkg::TIME_W-1:0] now,
                               input logic [mkpd_pkg::MATRIX_W-1:0] keys,
                               output mkpd_pkg::scan_result_type res);
      logic [mkpd_pkg::MATRIX_W-1:0] active;
      logic [mkpd_pkg::MATRIX_W-1:0] row_bits;
      logic [mkpd_pkg::IDX_W-1:0]    entry;
      logic [mkpd_pkg::CODE_W-1:0]   code;
      logic [mkpd_pkg::TIME_W-1:0]   elapsed;
      int                            col;
      res = '0;
      active = keys & mkpd_pkg::MATRIX_W'((32'd1 << (ROWS * COLS)) - 1);
      if (m_waiting) begin
         if (active == '0)
            m_waiting = 1'b0;
         return;
      end
      if (m_row < ROWS) begin
         row_bits = (active >> (m_row * COLS)) & mkpd_pkg::MATRIX_W'((1 << COLS) - 1);
         if (row_bits != '0) begin
            col = 0;
            for (int c = COLS - 1; c >= 0; c--)
               if (row_bits[c])
                  col = c;
            entry = mkpd_pkg::IDX_W'(m_row * COLS + col);
            code = entry[3] ? m_map_hi[8*entry[2:0] +: 8] : m_map_lo[8*entry[2:0] +: 8];
            elapsed = now - m_last_ms;
            if (elapsed >= m_debounce || code != m_last_code) begin
               m_last_code   = code;
               m_last_ms     = now;
               m_waiting     = 1'b1;
               res.key_event = 1'b1;
               res.key_code  = code;
               return;
            end
         end
      end
      m_row = (m_row + 1 >= ROWS) ? '0 : m_row + 1'b1;
   endtask

   task automatic send_tick(input logic [mkpd_pkg::TIME_W-1:0] now,
                            input logic [mkpd_pkg::MATRIX_W-1:0] keys);
      mkpd_pkg::scan_result_type res;
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {keys, now};
      do @(posedge clock); while (!req_tready);
      predict_scan(now, keys, res);
      pending_results.push_back(res);
   endtask

   task automatic write_csr(input logic [mkpd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [mkpd_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         mkpd_pkg::CSR_DEBOUNCE_TIME: m_debounce = data[mkpd_pkg::TIME_W-1:0];
         mkpd_pkg::CSR_KEYMAP_LOW:    m_map_lo   = data;
         mkpd_pkg::CSR_KEYMAP_HIGH:   m_map_hi   = data;
         default: ;         // unmapped index, write dropped
      endcase
   endtask

   // drain the pipeline so the block is idle before register writes
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void advance_ms();
      case ($urandom_range(99)) inside
         [0:2]:   tick_ms = $urandom;                      // arbitrary jump
         [3:5]:   tick_ms = tick_ms - $urandom_range(1, 100); // goes backwards
         default: tick_ms = tick_ms + $urandom_range(0, 25);
      endcase
   endfunction

   // keymap with codes 0..3 only, so equal codes from different keys are common
   function automatic logic [mkpd_pkg::MAP_W-1:0] few_code_map();
      logic [mkpd_pkg::MAP_W-1:0] m;
      for (int i = 0; i < 8; i++)
         m[8*i +: 8] = 8'($urandom_range(0, 3));
      return m;
   endfunction

   task automatic run_random(input int n_ticks);
      logic [mkpd_pkg::MATRIX_W-1:0] keys;
      int sent;
      int hold;
      sent = 0;
      while (sent < n_ticks) begin
         if ($urandom_range(99) < 75) begin
            // press, hold, release
            keys = mkpd_pkg::MATRIX_W'(1) << $urandom_range(0, mkpd_pkg::MATRIX_W - 1);
            if ($urandom_range(3) == 0)
               keys |= mkpd_pkg::MATRIX_W'(1) << $urandom_range(0, mkpd_pkg::MATRIX_W - 1);
            hold = $urandom_range(1, 10);
            sent += hold;
            repeat (hold) begin
               advance_ms();
               send_tick(tick_ms, keys);
            end
            hold = $urandom_range(1, 3);
            sent += hold;
            repeat (hold) begin
               advance_ms();
               send_tick(tick_ms, '0);
            end
         end else begin
            advance_ms();
            send_tick(tick_ms, mkpd_pkg::MATRIX_W'($urandom));
            sent++;
         end
      end
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input logic [31:0] deb,
                            input logic [mkpd_pkg::MAP_W-1:0] map_lo,
                            input logic [mkpd_pkg::MAP_W-1:0] map_hi);
      settle();
      write_csr(mkpd_pkg::CSR_DEBOUNCE_TIME, {$urandom, deb});
      write_csr(mkpd_pkg::CSR_KEYMAP_LOW, map_lo);
      write_csr(mkpd_pkg::CSR_KEYMAP_HIGH, map_hi);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      run_random(PHASE_ITEMS);
   endtask

   // reset values: empty keymap, so the first press matches the last code and is debounced
   task automatic test_power_on_defaults();
      send_tick(32'd10, 16'h0001);
      send_tick(32'd20, 16'h0000);
      send_tick(32'd30, 16'h0000);
      send_tick(32'd40, 16'h0000);
      send_tick(32'd100, 16'h0001);  // code zero still reported
      send_tick(32'd101, 16'h0001);
      send_tick(32'd102, 16'h0000);
   endtask

   task automatic test_key_selection();
      settle();
      write_csr(CSR_INDEX_UNUSED, '1);
      write_csr(mkpd_pkg::CSR_DEBOUNCE_TIME, 64'hFFFF_FFFF);
      write_csr(mkpd_pkg::CSR_KEYMAP_LOW, 64'h0706_0504_0302_01FF);
      write_csr(mkpd_pkg::CSR_KEYMAP_HIGH, 64'h000F_0E0D_0C0B_0A09);
      send_tick(32'd200, 16'h000E);  // lowest column wins
      send_tick(32'd201, 16'h0000);
      send_tick(32'd202, 16'hFFFF);
      send_tick(32'd203, 16'h0000);
      send_tick(32'd204, 16'h0001);  // same code inside debounce window
      send_tick(32'd205, 16'h00F0);
      send_tick(32'd206, 16'h0000);
      send_tick(32'd207, 16'h0000);
      send_tick(32'd208, 16'h0C00);
      send_tick(32'd209, 16'h0000);
   endtask

   task automatic test_time_wrap();
      settle();
      write_csr(mkpd_pkg::CSR_DEBOUNCE_TIME, 64'd100);
      send_tick(32'h0000_0005, 16'h0C00);  // timestamp behind last report
      send_tick(32'hFFFF_FFFF, 16'h0000);
      send_tick(32'hFFFF_FFFF, 16'hFFFF);
      send_tick(32'h0000_0000, 16'h0000);
   endtask

   task automatic test_random_phases();
      tick_ms = 32'd1000;
      run_phase(0, 0, 32'd20, {$urandom, $urandom}, {$urandom, $urandom});
      run_phase(60, 0, 32'd0, few_code_map(), '1);
      run_phase(0, 60, 32'hFFFF_FFFF, '0, few_code_map());
      run_phase(34, 34, 32'($urandom_range(0, 80)), {$urandom, $urandom}, {$urandom, $urandom});
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with nothing expected: key_event %0d key_code %0h",
                   rsp_tuser, rsp_tdata);
            errors++;
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_tuser !== oldest_result.key_event) begin
               $error("key_event: expected %0d, got %0d", oldest_result.key_event, rsp_tuser);
               errors++;
            end
            if (rsp_tdata !== oldest_result.key_code) begin
               $error("key_code: expected %0h, got %0h", oldest_result.key_code, rsp_tdata);
               errors++;
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_power_on_defaults();
      test_key_selection();
      test_time_wrap();
      test_random_phases();
      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/mkpd_pkg.sv
rtl/mkpd_scan_core.sv
rtl/matrix_keypad_scan_debounce.sv
tb/sv/tb.sv
